@@ sv/rta_pkg.sv @@
// ----------------------------------------------------------------------------
// rta_pkg: shared constants and helpers for the radix to ASCII digit unit
// Holds the field widths, the accepted range of bases and the conversion
// from a remainder to its ASCII digit character.
// ----------------------------------------------------------------------------
package rta_pkg;

   // Field widths of the request and response words.
   localparam int NUMBER_W = 32;
   localparam int RADIX_W  = 6;
   localparam int CHAR_W   = 7;
   localparam int REM_W    = 6;

   // Accepted range of bases.
   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

   // No conversion ever yields more than this many digits.
   localparam int RESULT_SLOTS = 31;

   // The widest magnitude that a non-negative 32-bit number can carry.
   localparam int MAG_MAX_W = 31;

   // Character constants.
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
   localparam logic [CHAR_W-1:0] LETTER_GAP = 7'd7;

   // Control strobes for the digit store.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

   // Remainder to ASCII: digits 0-9 and then letters A-Z.
   function automatic logic [CHAR_W-1:0] ascii_of(input logic [REM_W-1:0] rem);
      logic [CHAR_W-1:0] c;
      c = CHAR_ZERO + {1'b0, rem};
      if (c > CHAR_NINE) begin
         c = c + LETTER_GAP;
      end
      return c;
   endfunction

endpackage

@@ sv/rta_divider.sv @@
// ----------------------------------------------------------------------------
// rta_divider: shared restoring divider
// Divides an unsigned magnitude by a small base, one quotient bit per
// cycle, and pulses done when the quotient and the remainder are ready.
// ----------------------------------------------------------------------------
module rta_divider
   import rta_pkg::*;
#(
   parameter int DW = 31
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DW-1:0]      dividend,
   input  logic [RADIX_W-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient,
   output logic [REM_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});
   end

   // Step sequencing.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/rta_digit_store.sv @@
// ----------------------------------------------------------------------------
// rta_digit_store: remainder memory
// Keeps the remainders of one conversion and reads them back, registered,
// as ASCII digit characters.
// ----------------------------------------------------------------------------
module rta_digit_store
   import rta_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  store_ctl_type            ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_idx,
   input  logic [REM_W-1:0]         wr_rem,
   input  logic [$clog2(DEPTH)-1:0] rd_idx,
   output logic [CHAR_W-1:0]        rd_char
);

   logic [REM_W-1:0] mem [DEPTH];
   logic [REM_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_idx] <= wr_rem;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_char = ascii_of(rd_data_ff);

endmodule

@@ sv/radix_to_ascii_digits_unit.sv @@
// ----------------------------------------------------------------------------
// radix_to_ascii_digits_unit: integer to ASCII digits in bases 2 to 36
// Converts a non-negative number to its digit characters, most significant
// first, one response word per digit.
// ----------------------------------------------------------------------------
// Each request word carries a number and a base. The unit divides the number
// by the base repeatedly on one shared bit-serial divider, stores each
// remainder, then sends the digits most significant first as ASCII ('0'-'9',
// 'A'-'Z'), with tlast on the final digit; zero gives the single digit '0'.
// A base outside 2 to 36 or a negative number gives one word with tuser set,
// data zero and tlast set. The unit takes one request at a time. The divider
// works on MAG_W bits (MAG_W is NUMBER_BITS capped at 31); each digit is read
// back from the store in the fetch and load steps and then held on the
// response side until the response side is ready and takes it.
module radix_to_ascii_digits_unit
   import rta_pkg::*;
#(
   parameter int NUMBER_BITS = 31,
   parameter int DIGIT_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request: number [31:0], radix [37:32], zero padding [39:38].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // Response: digit_char [6:0], zero padding [7].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // Response flag: bad_request [0].
   output logic        rsp_tuser
);

   localparam int MAG_W = (NUMBER_BITS >= MAG_MAX_W) ? MAG_MAX_W : NUMBER_BITS;
   localparam int LIMIT = (DIGIT_SLOTS < RESULT_SLOTS) ? DIGIT_SLOTS : RESULT_SLOTS;
   localparam int IDX_W = $clog2(DIGIT_SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(LIMIT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FETCH,
      ST_LOAD,
      ST_SHOW
   } state_type;

   state_type         state_ff, state_in;
   logic              start_ff, start_in;
   logic [MAG_W-1:0]  value_ff, value_in;
   logic [RADIX_W-1:0] base_ff, base_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic [NUMBER_W-1:0] req_number;
   logic [RADIX_W-1:0]  req_radix;
   logic                req_bad;

   logic                div_done;
   logic [MAG_W-1:0]    div_quo;
   logic [REM_W-1:0]    div_rem;
   store_ctl_type       store_ctl;
   logic [CHAR_W-1:0]   store_char;

   // Request word fields and the range check.
   assign req_number = req_tdata[NUMBER_W-1:0];
   assign req_radix  = req_tdata[NUMBER_W +: RADIX_W];
   assign req_bad    = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX)
                       || req_number[NUMBER_W-1];

   // Shared divider.
   rta_divider #(
      .DW (MAG_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (value_ff),
      .divisor   (base_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Remainder memory.
   rta_digit_store #(
      .DEPTH (DIGIT_SLOTS)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_idx  (wr_idx_ff),
      .wr_rem  (div_rem),
      .rd_idx  (rd_idx_ff),
      .rd_char (store_char)
   );

   // Store strobes: write each remainder as it appears, read in the fetch step.
   always_comb begin
      store_ctl.wr_en = (state_ff == ST_DIVIDE) && div_done;
      store_ctl.rd_en = (state_ff == ST_FETCH);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      value_in     = value_ff;
      base_in      = base_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_bad_in   = 1'b1;
                  state_in     = ST_SHOW;
               end else begin
                  value_in  = req_number[MAG_W-1:0];
                  base_in   = req_radix;
                  wr_idx_in = '0;
                  start_in  = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if ((div_quo == '0) || (wr_idx_ff == LAST_SLOT)) begin
                  rd_idx_in = wr_idx_ff;
                  state_in  = ST_FETCH;
               end else begin
                  value_in  = div_quo;
                  wr_idx_in = wr_idx_ff + 1'b1;
                  start_in  = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = store_char;
            rsp_last_in  = (rd_idx_ff == '0);
            rsp_bad_in   = 1'b0;
            state_in     = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - 1'b1;
                  state_in  = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      base_ff     <= base_in;
      wr_idx_ff   <= wr_idx_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // No request word is taken while reset is held.
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule

@@ tb/tb_radix_to_ascii_digits_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_to_ascii_digits_unit: self-checking bench for the digit unit
// Sends request words (number, base) and predicts the ASCII digit words
// that each one yields, most significant first, with tlast on the final
// digit and tuser on a rejected request. Every response word is checked
// field by field against the oldest prediction. Both sides idle at random,
// and at one point the response side holds off long enough to stall input.
// ----------------------------------------------------------------------------
module tb_radix_to_ascii_digits_unit;
   import rta_pkg::*;

   // One predicted response word.
   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
      logic              bad_request;
   } digit_word_type;

   logic        clock;
   logic        reset;
   // Request: number [31:0], radix [37:32], zero padding [39:38].
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   // Response: digit_char [6:0], zero padding [7].
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   // Response flag: bad_request [0].
   logic        rsp_tuser;

   digit_word_type expected_digits[$];
   int          mismatch_count;
   bit          idling_on;
   int          sink_hold_cycles;

   radix_to_ascii_digits_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a 10 ns period.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Predict the digit words for one accepted request.
   function automatic void predict_digits(input logic [31:0] number,
                                          input logic [RADIX_W-1:0] radix);
      logic [30:0]      magnitude;
      logic [REM_W-1:0] remainders [RESULT_SLOTS];
      logic [REM_W-1:0] rem;
      int               count;
      digit_word_type   word;
      // Base out of range or a negative number: a single flagged word.
      if (radix < RADIX_MIN || radix > RADIX_MAX || number[31]) begin
         word.digit_char  = '0;
         word.last_digit  = 1'b1;
         word.bad_request = 1'b1;
         expected_digits.push_back(word);
         return;
      end
      // Repeated division, least significant remainder first.
      magnitude = number[30:0];
      count     = 0;
      do begin
         remainders[count] = REM_W'(magnitude % {25'd0, radix});
         count++;
         magnitude = magnitude / {25'd0, radix};
      end while (magnitude != 0 && count < RESULT_SLOTS);
      // Emit most significant first; letters follow straight on from nine.
      for (int k = 0; k < count; k++) begin
         rem = remainders[count - 1 - k];
         if (rem < REM_W'(10)) begin
            word.digit_char = CHAR_ZERO + {1'b0, rem};
         end else begin
            word.digit_char = CHAR_ZERO + LETTER_GAP + {1'b0, rem};
         end
         word.last_digit  = (k == count - 1);
         word.bad_request = 1'b0;
         expected_digits.push_back(word);
      end
   endfunction

   // Offer one request word, wait for it to be taken, then predict.
   task automatic send_request(input logic [31:0] number,
                               input logic [RADIX_W-1:0] radix);
      int gap;
      gap = idling_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {2'b00, radix, number};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_digits(number, radix);
   endtask

   // Response side: random stalls per word, and a long hold when asked.
   initial begin : sink_control
      int stall;
      @(negedge reset);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end
         stall = idling_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid && sink_hold_cycles == 0);
      end
   end

   // Compare every accepted response word with the oldest prediction.
   always @(posedge clock) begin : check_words
      digit_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected word: data %h last %b user %b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end else begin
            want = expected_digits.pop_front();
            if (rsp_tdata !== {1'b0, want.digit_char} || rsp_tlast !== want.last_digit ||
                rsp_tuser !== want.bad_request) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected data %h last %b user %b, got %h %b %b",
                           {1'b0, want.digit_char}, want.last_digit, want.bad_request,
                           rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
      end
   end

   // Zero and the largest magnitude in small, decimal and large bases.
   task automatic test_extremes();
      send_request(32'd0, 6'd2);
      send_request(32'd0, 6'd10);
      send_request(32'd0, 6'd36);
      send_request(32'd1, 6'd2);
      send_request(32'h7FFF_FFFF, 6'd2);
      send_request(32'h7FFF_FFFF, 6'd10);
      send_request(32'h7FFF_FFFF, 6'd36);
   endtask

   // Digits either side of the step from nine to the letters, and the top letter.
   task automatic test_digit_letters();
      send_request(32'd9, 6'd10);
      send_request(32'd10, 6'd11);
      send_request(32'd35, 6'd36);
      send_request(32'h1234_5678, 6'd16);
      send_request(32'd1295, 6'd36);
   endtask

   // Bases below and above the range, and negative numbers.
   task automatic test_bad_requests();
      send_request(32'd100, 6'd0);
      send_request(32'd100, 6'd1);
      send_request(32'd100, 6'd37);
      send_request(32'hFFFF_FFFF, 6'd63);
      send_request(32'hFFFF_FFFF, 6'd10);
      send_request(32'h8000_0000, 6'd16);
   endtask

   // Mostly well-formed requests of varied length, with some rejected ones.
   task automatic test_random_mix(input int count);
      int                 kind;
      int                 width;
      int                 pick;
      logic [31:0]        number;
      logic [RADIX_W-1:0] radix;
      for (int i = 0; i < count; i++) begin
         kind   = $urandom_range(0, 19);
         number = $urandom;
         radix  = RADIX_W'($urandom_range(2, 36));
         if (kind < 16) begin
            width  = $urandom_range(0, 31);
            number = number & ~(32'hFFFF_FFFF << width);
         end else if (kind < 18) begin
            number[31] = 1'b1;
         end else if (kind == 18) begin
            pick  = $urandom_range(0, 28);
            radix = RADIX_W'((pick < 2) ? pick : pick + 35);
         end else begin
            radix = RADIX_W'($urandom_range(0, 63));
         end
         send_request(number, radix);
      end
   endtask

   // Back to back words on both sides.
   task automatic test_no_idling();
      idling_on = 1'b0;
      test_random_mix(30);
      idling_on = 1'b1;
   endtask

   // Response side holds off while requests keep coming, so input stalls.
   task automatic test_back_pressure();
      sink_hold_cycles = 400;
      for (int i = 0; i < 10; i++) begin
         send_request($urandom & 32'h7FFF_FFFF, RADIX_W'($urandom_range(2, 36)));
      end
   endtask

   // Reset, run the tests in turn, drain and report.
   initial begin
      reset            <= 1'b1;
      req_tvalid       <= 1'b0;
      req_tdata        <= '0;
      rsp_tready       <= 1'b0;
      mismatch_count   = 0;
      idling_on        = 1'b1;
      sink_hold_cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_digit_letters();
      test_bad_requests();
      test_back_pressure();
      test_no_idling();
      test_random_mix(370);

      req_tvalid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Guard against a hung run.
   initial begin
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
